@@ hdl/cse_pkg.sv @@
package cse_pkg;

    localparam int MEM_ADDR_BITS = 16;

    localparam logic [15:0] STACK_PAGE = 16'h0100;
    localparam logic [15:0] PC_RESET   = 16'hFFFC;
    localparam logic [7:0]  SP_RESET   = 8'hFF;
    localparam logic [7:0]  ST_RESET   = 8'h04;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_J = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    typedef enum logic [5:0] {
        OP_BRK = 6'd0,  OP_RTI = 6'd1,  OP_RTS = 6'd2,  OP_PHP = 6'd3,
        OP_CLC = 6'd4,  OP_PLP = 6'd5,  OP_SEC = 6'd6,  OP_CLI = 6'd7,
        OP_PLA = 6'd8,  OP_SEI = 6'd9,  OP_DEY = 6'd10, OP_TYA = 6'd11,
        OP_TAY = 6'd12, OP_CLV = 6'd13, OP_INX = 6'd14, OP_SED = 6'd15,
        OP_TXA = 6'd16, OP_TXS = 6'd17, OP_TAX = 6'd18, OP_TSX = 6'd19,
        OP_DEX = 6'd20, OP_JMP = 6'd21, OP_BPL = 6'd22, OP_JSR = 6'd23,
        OP_BMI = 6'd24, OP_BVC = 6'd25, OP_BVS = 6'd26, OP_BCC = 6'd27,
        OP_LDY = 6'd28, OP_BCS = 6'd29, OP_CPY = 6'd30, OP_BNE = 6'd31,
        OP_CPX = 6'd32, OP_BEQ = 6'd33, OP_BIT = 6'd34, OP_STY = 6'd35,
        OP_ORA = 6'd36, OP_AND = 6'd37
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MEM1,
        ST_MEM2,
        ST_MEM3,
        ST_OUT
    } t_state;

    // datapath step selected by the controller
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EXEC,
        CMD_MEM1,
        CMD_MEM2,
        CMD_MEM3,
        CMD_SHOW
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctrl;

    typedef struct packed {
        logic [1:0] mem_steps;   // number of stack accesses after exec (0..3)
    } t_stat;

endpackage

@@ hdl/cse_if.sv @@
interface cse_in_if;
    import cse_pkg::*;
    logic        valid;
    logic        ready;
    logic [5:0]  action;
    logic [15:0] operand;
    modport source (output valid, action, operand, input ready);
    modport sink   (input valid, action, operand, output ready);
endinterface

interface cse_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [15:0] pc_out;
    logic [7:0]  status_out;
    modport source (output valid, acc_out, x_out, y_out, sp_out, pc_out, status_out,
                    input ready);
    modport sink   (input valid, acc_out, x_out, y_out, sp_out, pc_out, status_out,
                    output ready);
endinterface

@@ hdl/cse_ctrl.sv @@
module cse_ctrl
    import cse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC: begin
                if (i_stat.mem_steps == 2'd0) n_state = ST_OUT;
                else n_state = ST_MEM1;
            end
            ST_MEM1: begin
                if (i_stat.mem_steps == 2'd1) n_state = ST_OUT;
                else n_state = ST_MEM2;
            end
            ST_MEM2: begin
                if (i_stat.mem_steps == 2'd2) n_state = ST_OUT;
                else n_state = ST_MEM3;
            end
            ST_MEM3: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = i_in_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctrl.cmd  = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctrl.cmd = CMD_LOAD;
            end
            ST_EXEC: o_ctrl.cmd = CMD_EXEC;
            ST_MEM1: o_ctrl.cmd = CMD_MEM1;
            ST_MEM2: o_ctrl.cmd = CMD_MEM2;
            ST_MEM3: o_ctrl.cmd = CMD_MEM3;
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready && i_in_valid) o_ctrl.cmd = CMD_LOAD;
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/cse_dp.sv @@
module cse_dp
    import cse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    input  logic [5:0]  i_action,
    input  logic [15:0] i_operand,
    output logic [7:0]  o_acc,
    output logic [7:0]  o_x,
    output logic [7:0]  o_y,
    output logic [7:0]  o_sp,
    output logic [15:0] o_pc,
    output logic [7:0]  o_st
);

    logic [7:0] r_mem [2**MEM_ADDR_BITS];

    logic [7:0]  r_a, r_x, r_y, r_sp, r_st;
    logic [15:0] r_pc;
    logic [5:0]  r_act;
    logic [15:0] r_opnd;
    logic [15:0] r_ret;
    logic [7:0]  r_rd;

    logic [7:0]  n_a, n_x, n_y, n_sp, n_st;
    logic [15:0] n_pc;

    logic [7:0]  imm, diff, rd_byte;
    logic [7:0]  cmp_reg;
    logic        take;
    logic [15:0] ret_addr;
    logic [7:0]  sp_inc;
    logic [MEM_ADDR_BITS-1:0] push_addr, pull_addr, sty_addr;
    logic        do_push;
    logic [7:0]  push_byte;
    logic [MEM_ADDR_BITS-1:0] wr_addr;

    assign imm      = r_opnd[7:0];
    assign ret_addr = r_pc + 16'd2;
    assign sp_inc   = r_sp + 8'd1;
    assign push_addr = MEM_ADDR_BITS'(STACK_PAGE + {8'd0, r_sp});
    // registered read: the slot above the next stack pointer
    assign pull_addr = MEM_ADDR_BITS'(STACK_PAGE + {8'd0, n_sp + 8'd1});
    assign sty_addr  = r_opnd[MEM_ADDR_BITS-1:0];
    assign rd_byte   = r_rd;
    assign cmp_reg   = (r_act == OP_CPX) ? r_x : r_y;
    assign diff      = cmp_reg - imm;

    always_comb begin
        case (r_act)
            OP_BPL:  take = !r_st[FLAG_N];
            OP_BMI:  take =  r_st[FLAG_N];
            OP_BVC:  take = !r_st[FLAG_V];
            OP_BVS:  take =  r_st[FLAG_V];
            OP_BCC:  take = !r_st[FLAG_C];
            OP_BCS:  take =  r_st[FLAG_C];
            OP_BNE:  take = !r_st[FLAG_Z];
            OP_BEQ:  take =  r_st[FLAG_Z];
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        case (r_act) inside
            OP_BRK:                 o_stat.mem_steps = 2'd3;
            OP_RTI:                 o_stat.mem_steps = 2'd3;
            OP_RTS, OP_JSR:         o_stat.mem_steps = 2'd2;
            OP_PHP, OP_PLP, OP_PLA: o_stat.mem_steps = 2'd1;
            default:                o_stat.mem_steps = 2'd0;
        endcase
    end

    // one stack access per memory step; exec step does register and flag work, jumps, branches and STY
    always_comb begin
        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_pc = r_pc; n_st = r_st;
        do_push = 1'b0; push_byte = r_st; wr_addr = push_addr;
        case (i_ctrl.cmd)
            CMD_EXEC: begin
                unique case (r_act) inside
                    OP_BRK: n_st = r_st | 8'h14;
                    OP_CLC: n_st[FLAG_C] = 1'b0;
                    OP_SEC: n_st[FLAG_C] = 1'b1;
                    OP_CLI: n_st[FLAG_I] = 1'b0;
                    OP_SEI: n_st[FLAG_I] = 1'b1;
                    OP_CLV: n_st[FLAG_V] = 1'b0;
                    OP_SED: n_st[FLAG_D] = 1'b1;
                    OP_DEY: n_y = r_y - 8'd1;
                    OP_TYA: n_a = r_y;
                    OP_TAY: n_y = r_a;
                    OP_INX: n_x = r_x + 8'd1;
                    OP_TXA: n_a = r_x;
                    OP_TXS: n_sp = r_x;
                    OP_TAX: n_x = r_a;
                    OP_TSX: n_x = r_sp;
                    OP_DEX: n_x = r_x - 8'd1;
                    OP_LDY: n_y = imm;
                    OP_ORA: n_a = r_a | imm;
                    OP_AND: n_a = r_a & imm;
                    OP_JMP: begin
                        n_pc = r_opnd;
                        n_st[FLAG_J] = 1'b1;
                    end
                    OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ: begin
                        if (take) begin
                            n_pc = r_pc + {{8{imm[7]}}, imm};
                            n_st[FLAG_J] = 1'b1;
                        end
                    end
                    OP_CPX, OP_CPY: begin
                        n_st[FLAG_N] = diff[7];
                        n_st[FLAG_Z] = (cmp_reg == imm);
                        n_st[FLAG_C] = (cmp_reg >= imm);
                    end
                    OP_BIT: begin
                        n_st[FLAG_N] = imm[7];
                        n_st[FLAG_V] = imm[6];
                        n_st[FLAG_Z] = ((r_a & imm) == 8'd0);
                    end
                    OP_STY: begin
                        do_push = 1'b1;
                        push_byte = r_y;
                        wr_addr = sty_addr;
                    end
                    default: ;
                endcase
                case (r_act) inside
                    OP_DEY, OP_TAY, OP_LDY: begin
                        n_st[FLAG_N] = n_y[7];
                        n_st[FLAG_Z] = (n_y == 8'd0);
                    end
                    OP_TYA, OP_TXA, OP_ORA, OP_AND: begin
                        n_st[FLAG_N] = n_a[7];
                        n_st[FLAG_Z] = (n_a == 8'd0);
                    end
                    OP_INX, OP_TAX, OP_TSX, OP_DEX: begin
                        n_st[FLAG_N] = n_x[7];
                        n_st[FLAG_Z] = (n_x == 8'd0);
                    end
                    default: ;
                endcase
            end
            CMD_MEM1, CMD_MEM2, CMD_MEM3: begin
                case (r_act) inside
                    OP_BRK, OP_JSR: begin
                        do_push = 1'b1;
                        n_sp = r_sp - 8'd1;
                        if (i_ctrl.cmd == CMD_MEM1) push_byte = r_ret[15:8];
                        else if (i_ctrl.cmd == CMD_MEM2) push_byte = r_ret[7:0];
                        else push_byte = r_st;
                        if (r_act == OP_JSR && i_ctrl.cmd == CMD_MEM2) begin
                            n_pc = r_opnd;
                            n_st[FLAG_J] = 1'b1;
                        end
                        if (r_act == OP_BRK && i_ctrl.cmd == CMD_MEM3) n_st[FLAG_J] = 1'b1;
                    end
                    OP_PHP: begin
                        do_push = 1'b1;
                        n_sp = r_sp - 8'd1;
                    end
                    OP_PLP: begin
                        n_sp = sp_inc;
                        n_st = rd_byte;
                    end
                    OP_PLA: begin
                        n_sp = sp_inc;
                        n_a = rd_byte;
                        n_st[FLAG_N] = rd_byte[7];
                        n_st[FLAG_Z] = (rd_byte == 8'd0);
                    end
                    OP_RTS: begin
                        n_sp = sp_inc;
                        if (i_ctrl.cmd == CMD_MEM1) n_pc[7:0] = rd_byte;
                        else begin
                            n_pc[15:8] = rd_byte;
                            n_st[FLAG_J] = 1'b1;
                        end
                    end
                    OP_RTI: begin
                        n_sp = sp_inc;
                        if (i_ctrl.cmd == CMD_MEM1) n_st = rd_byte;
                        else if (i_ctrl.cmd == CMD_MEM2) n_pc[7:0] = rd_byte;
                        else begin
                            n_pc[15:8] = rd_byte;
                            n_st[FLAG_J] = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[wr_addr] <= push_byte;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[pull_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= 8'd0; r_x <= 8'd0; r_y <= 8'd0;
            r_sp <= SP_RESET; r_pc <= PC_RESET; r_st <= ST_RESET;
        end else begin
            r_a <= n_a; r_x <= n_x; r_y <= n_y;
            r_sp <= n_sp; r_pc <= n_pc; r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd == CMD_LOAD) begin
            r_act  <= i_action;
            r_opnd <= i_operand;
        end
        if (i_ctrl.cmd == CMD_EXEC) r_ret <= ret_addr;
    end

    assign o_acc = r_a;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_sp  = r_sp;
    assign o_pc  = r_pc;
    assign o_st  = r_st;

endmodule

@@ hdl/cpu6502_subset_execute.sv @@
// Executes one decoded instruction of a 6502-style subset per input word.
// Input channel: action (instruction select) and operand; a word is taken
// when valid and ready are both high. Output channel: the full register set
// after the instruction, one word per input word.
// Steps: a load step, an execute step, then one memory step per stack
// access (BRK and RTI three, JSR and RTS two, PHP/PLP/PLA one), then the
// result is shown. The stack accesses of BRK, JSR, RTS and RTI are done
// one per memory step.
// The result register holds its word while the receiver stalls; a new input
// word is taken in the same cycle that the result is taken.
// Reset: A, X, Y cleared, SP = 0xFF, PC = 0xFFFC, status = 0x04. The stack
// memory is not cleared; pulling an unwritten byte is undefined.
// The block works on one instruction at a time.
module cpu6502_subset_execute
    import cse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cse_in_if.sink    i_in,
    cse_out_if.source o_out
);

    t_ctrl ctrl;
    t_stat stat;

    cse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    cse_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .o_stat    (stat),
        .i_action  (i_in.action),
        .i_operand (i_in.operand),
        .o_acc     (o_out.acc_out),
        .o_x       (o_out.x_out),
        .o_y       (o_out.y_out),
        .o_sp      (o_out.sp_out),
        .o_pc      (o_out.pc_out),
        .o_st      (o_out.status_out)
    );

endmodule

@@ hdl/cse_checker.sv @@
module cse_checker
    import cse_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_sp,
    input logic [7:0]  i_st
);

    a_no_accept_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken twice in a row");

    a_no_out_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("result shown right after input");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sp) && $stable(i_st)))
        else $error("result changed while stalled");

    a_ready_only_idle_or_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while result stalled");

endmodule

bind cpu6502_subset_execute cse_checker u_cse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sp        (o_out.sp_out),
    .i_st        (o_out.status_out)
);

@@ tb/cpu6502_subset_execute_test.sv @@
module cpu6502_subset_execute_test;
    import cse_pkg::*;

    typedef struct {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [15:0] pc;
        logic [7:0]  st;
    } t_regs;

    logic i_clk;
    logic i_rst_n;

    cse_in_if  in_if ();
    cse_out_if out_if ();

    cpu6502_subset_execute u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // architectural copy, updated as words are issued (one stream, in order)
    t_regs       arch;
    logic [7:0]  stack_mem [256];
    bit          stack_written [256];
    t_regs       arch_q [$];

    int   err_cnt;
    bit   tx_no_idle;
    bit   rx_no_idle;
    event hold_go;
    bit   hold_on;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_cnt++;
    endtask

    function automatic void stack_push(input logic [7:0] v);
        stack_mem[arch.sp]     = v;
        stack_written[arch.sp] = 1'b1;
        arch.sp                = arch.sp - 8'd1;
    endfunction

    function automatic logic [7:0] stack_pull();
        arch.sp = arch.sp + 8'd1;
        return stack_mem[arch.sp];
    endfunction

    function automatic void set_nz(input logic [7:0] r);
        arch.st[FLAG_N] = r[7];
        arch.st[FLAG_Z] = (r == 8'd0);
    endfunction

    function automatic void branch_on(input bit cond, input logic [7:0] off);
        if (cond) begin
            arch.pc         = arch.pc + {{8{off[7]}}, off};
            arch.st[FLAG_J] = 1'b1;
        end
    endfunction

    function automatic void compare_reg(input logic [7:0] r, input logic [7:0] imm);
        logic [7:0] diff;
        diff            = r - imm;
        arch.st[FLAG_N] = diff[7];
        arch.st[FLAG_Z] = (r == imm);
        arch.st[FLAG_C] = (r >= imm);
    endfunction

    function automatic void push_return();
        logic [15:0] ret;
        ret = arch.pc + 16'd2;
        stack_push(ret[15:8]);
        stack_push(ret[7:0]);
    endfunction

    function automatic void pull_pc();
        logic [7:0] lo;
        logic [7:0] hi;
        lo      = stack_pull();
        hi      = stack_pull();
        arch.pc = {hi, lo};
    endfunction

    // pulls must only touch stack bytes already written
    function automatic bit pull_safe(input logic [5:0] act);
        int n;
        logic [7:0] a;
        case (t_op'(act)) inside
            OP_RTI:         n = 3;
            OP_RTS:         n = 2;
            OP_PLP, OP_PLA: n = 1;
            default:        n = 0;
        endcase
        for (int k = 1; k <= n; k++) begin
            a = arch.sp + k[7:0];
            if (!stack_written[a]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void execute_word(input logic [5:0] act, input logic [15:0] opnd);
        logic [7:0] imm;
        logic [7:0] f;
        logic [15:0] sta;
        imm = opnd[7:0];
        f   = arch.st;
        case (t_op'(act))
            OP_BRK: begin
                arch.st[FLAG_I] = 1'b1;
                arch.st[FLAG_B] = 1'b1;
                push_return();
                stack_push(arch.st);
                arch.st[FLAG_J] = 1'b1;
            end
            OP_RTI: begin
                arch.st = stack_pull();
                pull_pc();
                arch.st[FLAG_J] = 1'b1;
            end
            OP_RTS: begin
                pull_pc();
                arch.st[FLAG_J] = 1'b1;
            end
            OP_PHP: stack_push(arch.st);
            OP_CLC: arch.st[FLAG_C] = 1'b0;
            OP_PLP: arch.st = stack_pull();
            OP_SEC: arch.st[FLAG_C] = 1'b1;
            OP_CLI: arch.st[FLAG_I] = 1'b0;
            OP_PLA: begin arch.acc = stack_pull(); set_nz(arch.acc); end
            OP_SEI: arch.st[FLAG_I] = 1'b1;
            OP_DEY: begin arch.y = arch.y - 8'd1; set_nz(arch.y); end
            OP_TYA: begin arch.acc = arch.y; set_nz(arch.acc); end
            OP_TAY: begin arch.y = arch.acc; set_nz(arch.y); end
            OP_CLV: arch.st[FLAG_V] = 1'b0;
            OP_INX: begin arch.x = arch.x + 8'd1; set_nz(arch.x); end
            OP_SED: arch.st[FLAG_D] = 1'b1;
            OP_TXA: begin arch.acc = arch.x; set_nz(arch.acc); end
            OP_TXS: arch.sp = arch.x;
            OP_TAX: begin arch.x = arch.acc; set_nz(arch.x); end
            OP_TSX: begin arch.x = arch.sp; set_nz(arch.x); end
            OP_DEX: begin arch.x = arch.x - 8'd1; set_nz(arch.x); end
            OP_JMP: begin arch.pc = opnd; arch.st[FLAG_J] = 1'b1; end
            OP_BPL: branch_on(!f[FLAG_N], imm);
            OP_JSR: begin
                push_return();
                arch.pc         = opnd;
                arch.st[FLAG_J] = 1'b1;
            end
            OP_BMI: branch_on(f[FLAG_N], imm);
            OP_BVC: branch_on(!f[FLAG_V], imm);
            OP_BVS: branch_on(f[FLAG_V], imm);
            OP_BCC: branch_on(!f[FLAG_C], imm);
            OP_LDY: begin arch.y = imm; set_nz(arch.y); end
            OP_BCS: branch_on(f[FLAG_C], imm);
            OP_CPY: compare_reg(arch.y, imm);
            OP_BNE: branch_on(!f[FLAG_Z], imm);
            OP_CPX: compare_reg(arch.x, imm);
            OP_BEQ: branch_on(f[FLAG_Z], imm);
            OP_BIT: begin
                arch.st[FLAG_N] = imm[7];
                arch.st[FLAG_V] = imm[6];
                arch.st[FLAG_Z] = ((arch.acc & imm) == 8'd0);
            end
            OP_STY: begin
                // address wraps at the memory size; only the stack page is read back
                sta = 16'(32'(opnd) & ((32'd1 << MEM_ADDR_BITS) - 32'd1));
                if (sta[15:8] == STACK_PAGE[15:8]) begin
                    stack_mem[sta[7:0]]     = arch.y;
                    stack_written[sta[7:0]] = 1'b1;
                end
            end
            OP_ORA: begin arch.acc = arch.acc | imm; set_nz(arch.acc); end
            OP_AND: begin arch.acc = arch.acc & imm; set_nz(arch.acc); end
            default: ;
        endcase
    endfunction

    function automatic int rand_gap(input bit no_idle);
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // issue one word; an unsafe pull becomes a PHP
    task automatic send_word(input logic [5:0] act, input logic [15:0] opnd);
        int gap;
        if (!pull_safe(act)) act = OP_PHP;
        execute_word(act, opnd);
        arch_q.push_back(arch);
        gap = rand_gap(tx_no_idle);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.action  <= act;
        in_if.operand <= opnd;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // long receiver hold, counted here in cycles
    initial begin
        hold_on <= 1'b0;
        forever begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (300) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        int   stall_left;
        t_regs e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (arch_q.size() == 0) begin
                    report_mismatch("result word with nothing pending");
                end else begin
                    e = arch_q.pop_front();
                    if (out_if.acc_out !== e.acc)
                        report_mismatch($sformatf("acc %h exp %h", out_if.acc_out, e.acc));
                    if (out_if.x_out !== e.x)
                        report_mismatch($sformatf("x %h exp %h", out_if.x_out, e.x));
                    if (out_if.y_out !== e.y)
                        report_mismatch($sformatf("y %h exp %h", out_if.y_out, e.y));
                    if (out_if.sp_out !== e.sp)
                        report_mismatch($sformatf("sp %h exp %h", out_if.sp_out, e.sp));
                    if (out_if.pc_out !== e.pc)
                        report_mismatch($sformatf("pc %h exp %h", out_if.pc_out, e.pc));
                    if (out_if.status_out !== e.st)
                        report_mismatch($sformatf("status %h exp %h",
                                                  out_if.status_out, e.st));
                end
            end
            if (hold_on) begin
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!rx_no_idle && $urandom_range(0, 99) < 25) begin
                stall_left = rand_gap(1'b0);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] rand_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: v[7:0] = 8'h00;
            1: v[7:0] = 8'hFF;
            2: v[7:0] = 8'h80;
            3: v[7:0] = 8'h7F;
            4: v[15:8] = STACK_PAGE[15:8];
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] rand_plain_op();
        if ($urandom_range(0, 99) < 8) return 6'($urandom_range(38, 63));
        return 6'($urandom_range(0, 37));
    endfunction

    task automatic test_directed();
        send_word(OP_LDY, 16'h00FF);
        send_word(OP_TYA, 16'h0000);
        send_word(OP_TAX, 16'h0000);
        send_word(OP_INX, 16'h0000);
        send_word(OP_DEX, 16'h0000);
        send_word(OP_DEY, 16'h0000);
        send_word(OP_CPX, 16'h0001);
        send_word(OP_CPY, 16'h0080);
        send_word(OP_BIT, 16'h00C0);
        send_word(OP_ORA, 16'h0080);
        send_word(OP_AND, 16'h0000);
        send_word(OP_SEC, 16'h0000);
        send_word(OP_BCS, 16'h007F);
        send_word(OP_BCC, 16'h0080);
        send_word(OP_BEQ, 16'h0080);
        send_word(OP_JMP, 16'hFFFF);
        send_word(OP_JSR, 16'h0000);
        send_word(OP_PHP, 16'h0000);
        send_word(OP_PLP, 16'h0000);
        send_word(OP_RTS, 16'h0000);
        send_word(OP_BRK, 16'h0000);
        send_word(OP_RTI, 16'h0000);
        send_word(OP_LDY, 16'h01A5);
        send_word(OP_STY, 16'h01FF);
        send_word(6'd63, 16'hFFFF);
    endtask

    task automatic test_random(input int n_words);
        int sent;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 99) < 35) begin
                // call or interrupt frame with random body, then its return
                automatic bit is_brk = 1'($urandom_range(0, 1));
                automatic int body   = $urandom_range(0, 4);
                send_word(is_brk ? OP_BRK : OP_JSR, rand_operand());
                for (int k = 0; k < body; k++) begin
                    automatic logic [5:0] op = rand_plain_op();
                    if (op == OP_TXS) op = OP_TSX;
                    send_word(op, rand_operand());
                end
                send_word(is_brk ? OP_RTI : OP_RTS, rand_operand());
                sent += body + 2;
            end else begin
                send_word(rand_plain_op(), rand_operand());
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        -> hold_go;
        tx_no_idle = 1'b1;
        for (int k = 0; k < 30; k++) send_word(rand_plain_op(), rand_operand());
        tx_no_idle = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (arch_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin
        err_cnt       = 0;
        tx_no_idle    = 1'b0;
        rx_no_idle    = 1'b0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.action  = '0;
        in_if.operand = '0;
        arch.acc = 8'd0;
        arch.x   = 8'd0;
        arch.y   = 8'd0;
        arch.sp  = SP_RESET;
        arch.pc  = PC_RESET;
        arch.st  = ST_RESET;
        for (int k = 0; k < 256; k++) begin
            stack_mem[k]     = 8'd0;
            stack_written[k] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(600);
        test_backpressure();
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        test_random(200);
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        test_random(500);

        in_if.valid <= 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && arch_q.size() == 0) begin
            $display("cpu6502_subset_execute_test: clean");
        end else begin
            if (arch_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", arch_q.size()));
            $display("cpu6502_subset_execute_test: errors");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("cpu6502_subset_execute_test: errors");
        $finish;
    end

endmodule
